[rtl/core/lhp_pkg.sv]
// Package for the latency histogram core: shared constants, codes and the
// command word passed from the front end to the back end. No dependencies.
`default_nettype none

package lhp_pkg;

  localparam int unsigned BUCKET_COUNT_DEF = 512;
  localparam int unsigned COUNT_WIDTH_DEF  = 32;
  localparam int unsigned BUCKET_MAX       = 4096;
  localparam int unsigned IDX_MAX_W        = $clog2(BUCKET_MAX);

  localparam logic [15:0] WIDTH_RESET = 16'd1000;

  localparam int unsigned RANK_SCALE_W = 17;
  localparam logic [RANK_SCALE_W-1:0] RANK_SCALE = 17'd100000;
  localparam logic [RANK_SCALE_W-1:0] RANK_K [4] = '{17'd50000, 17'd99000, 17'd99900,
                                                     17'd99990};

  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_RPT = 2'd1;
  localparam logic [1:0] FUNC_CLR = 2'd2;
  localparam logic [1:0] FUNC_RSV = 2'd3;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_RPT,
    OP_CLR
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic                 ovf;
    logic [IDX_MAX_W-1:0] idx;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/core/lhp_if.sv]
// Channel interfaces of the latency histogram core: input words, result
// words and the width register write channel. No dependencies.
`default_nettype none

interface lhp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [31:0] sample_ns;
  modport source (output valid, func, sample_ns, input ready);
  modport sink (input valid, func, sample_ns, output ready);
endinterface

interface lhp_out_if;
  logic        valid;
  logic        ready;
  logic        is_empty;
  logic [24:0] min_ns;
  logic [24:0] max_ns;
  logic        sat_flag;
  logic [31:0] ovf_count;
  logic [25:0] p50_x2;
  logic [25:0] p99_x2;
  logic [25:0] p999_x2;
  logic [25:0] p9999_x2;
  modport source (output valid, is_empty, min_ns, max_ns, sat_flag, ovf_count,
                  p50_x2, p99_x2, p999_x2, p9999_x2, input ready);
  modport sink (input valid, is_empty, min_ns, max_ns, sat_flag, ovf_count,
                p50_x2, p99_x2, p999_x2, p9999_x2, output ready);
endinterface

interface lhp_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

[rtl/core/latency_histogram_percentiles_core.sv]
// Top level of the latency histogram core: width register, front end,
// command queue and back end. Depends on lhp_pkg, lhp_if and all lhp_ modules.
// An add holds the input from one accepted word to the next: the accept
// cycle, the one-bit-per-cycle 31-step divide by the bucket width in the
// front end and the hand-off of the command to the queue; the back end then
// updates the bucket in a read and a write state. A report of a non-empty
// histogram walks the buckets in the back end, one bucket memory read per
// cycle, drains the walk pipeline and scales min, max and the four percentiles
// on the shared width multiplier; a clear sweeps every bucket. After reset a
// clearing pass over all buckets runs with in_i.ready low. The width register
// may be written whenever the block is idle; a width of 0 acts as 1.
`default_nettype none

module latency_histogram_percentiles_core import lhp_pkg::*; #(
  parameter int unsigned BucketCount = BUCKET_COUNT_DEF,
  parameter int unsigned CountWidth  = COUNT_WIDTH_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  lhp_in_if.sink    in_i,
  lhp_out_if.source out_o,
  lhp_cfg_if.sink   cfg_i
);

  logic [15:0] width_q;
  logic [15:0] width_eff;
  cmd_t        f_cmd, b_cmd;
  logic        f_valid, f_ready, b_valid, b_ready;
  logic        init_busy;

  assign cfg_i.ready = 1'b1;
  assign width_eff   = (width_q == 16'd0) ? 16'd1 : width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_RESET;
    end else if (cfg_i.valid) begin
      width_q <= cfg_i.data;
    end
  end

  lhp_front #(.BucketCount(BucketCount)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .width_i     (width_eff),
    .init_busy_i (init_busy),
    .cmd_o       (f_cmd),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready)
  );

  lhp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (f_cmd),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .pop_data_o   (b_cmd),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready)
  );

  lhp_back #(.BucketCount(BucketCount), .CountWidth(CountWidth)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (b_cmd),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .width_i     (width_eff),
    .init_busy_o (init_busy),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

[rtl/core/lhp_fifo.sv]
// Two-entry command queue between front end and back end.
// Depends on lhp_pkg.
`default_nettype none

module lhp_fifo import lhp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t push_data_i,
  input  logic push_valid_i,
  output logic push_ready_o,
  output cmd_t pop_data_o,
  output logic pop_valid_o,
  input  logic pop_ready_i
);

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rp_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/lhp_front.sv]
// Front end: accept input words, divide samples by the bucket width and
// issue commands to the queue. Depends on lhp_pkg and lhp_if.
`default_nettype none

module lhp_front import lhp_pkg::*; #(
  parameter int unsigned BucketCount = BUCKET_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lhp_in_if.sink      in_i,
  input  logic [15:0] width_i,
  input  logic        init_busy_i,
  output cmd_t        cmd_o,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i
);

  localparam int unsigned BIDX_W = $clog2(BucketCount);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]  state_q;
  logic [30:0] num_q, quot_q;
  logic [15:0] rem_q;
  logic [4:0]  step_q;
  logic        accept;
  logic [16:0] trial;
  logic        ge;
  logic        is_ovf;

  assign in_i.ready = (state_q == F_IDLE) && !init_busy_i && cmd_ready_i;
  assign accept     = in_i.valid && in_i.ready;
  assign trial      = {rem_q, num_q[30]};
  assign ge         = (trial >= {1'b0, width_i});
  assign is_ovf     = (quot_q >= 31'(BucketCount));

  always_comb begin
    cmd_o.op    = OP_ADD;
    cmd_o.ovf   = is_ovf;
    cmd_o.idx   = IDX_MAX_W'(quot_q[BIDX_W-1:0]);
    cmd_valid_o = 1'b0;
    if (state_q == F_PUSH) begin
      cmd_valid_o = 1'b1;
    end else if (accept) begin
      case (in_i.func)
        FUNC_RPT: begin
          cmd_o.op    = OP_RPT;
          cmd_valid_o = 1'b1;
        end
        FUNC_CLR: begin
          cmd_o.op    = OP_CLR;
          cmd_valid_o = 1'b1;
        end
        default: cmd_valid_o = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      num_q   <= '0;
      quot_q  <= '0;
      rem_q   <= '0;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (accept && in_i.func == FUNC_ADD && !in_i.sample_ns[31]) begin
            num_q   <= in_i.sample_ns[30:0];
            quot_q  <= '0;
            rem_q   <= '0;
            step_q  <= '0;
            state_q <= F_DIV;
          end
        end
        F_DIV: begin
          num_q  <= {num_q[29:0], 1'b0};
          quot_q <= {quot_q[29:0], ge};
          rem_q  <= ge ? 16'(trial - {1'b0, width_i}) : trial[15:0];
          step_q <= step_q + 5'd1;
          if (step_q == 5'd30) begin
            state_q <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (cmd_ready_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/lhp_back.sv]
// Back end: bucket memory, counters, clear sweep, report walk and result
// register. Depends on lhp_pkg and lhp_if.
`default_nettype none

module lhp_back import lhp_pkg::*; #(
  parameter int unsigned BucketCount = BUCKET_COUNT_DEF,
  parameter int unsigned CountWidth  = COUNT_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  logic [15:0] width_i,
  output logic        init_busy_o,
  lhp_out_if.source   out_o
);

  localparam int unsigned BIDX_W = $clog2(BucketCount);
  localparam int unsigned CNT_W  = BIDX_W + 1;
  localparam int unsigned SCL_W  = CountWidth + RANK_SCALE_W;
  localparam int unsigned SUM_W  = SCL_W + BIDX_W;
  localparam int unsigned MW     = BIDX_W + 2;

  localparam logic [2:0] B_CLR    = 3'd0;
  localparam logic [2:0] B_IDLE   = 3'd1;
  localparam logic [2:0] B_ADD_RD = 3'd2;
  localparam logic [2:0] B_ADD_WR = 3'd3;
  localparam logic [2:0] B_WALK   = 3'd4;
  localparam logic [2:0] B_MUL    = 3'd5;

  logic [CountWidth-1:0] mem_q [BucketCount];
  logic [CountWidth-1:0] rdata_q;
  logic [BIDX_W-1:0]     rd_addr, wr_addr;
  logic [CountWidth-1:0] wr_data;
  logic                  wr_en;

  logic [2:0]            state_q;
  logic                  init_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [BIDX_W-1:0]     idx_q;
  logic [CountWidth-1:0] acc_q, ovf_q;

  logic                  v1_q, v2_q, v3_q;
  logic [BIDX_W-1:0]     i1_q, i2_q, i3_q;
  logic [SCL_W-1:0]      scaled_q;
  logic [SUM_W-1:0]      cum_q;
  logic [SCL_W-1:0]      kn_q [4];
  logic [3:0]            pf_q;
  logic [BIDX_W-1:0]     pidx_q [4];
  logic                  fmin_q;
  logic [BIDX_W-1:0]     min_idx_q, last_idx_q;
  logic [2:0]            step_q;

  logic                  out_valid_q, empty_q, sat_q;
  logic [31:0]           ovf_cnt_q;
  logic [24:0]           min_q, max_q;
  logic [25:0]           pct_q [4];

  logic                  pop, issue, walk_done;
  logic [MW-1:0]         mul_m;
  logic [MW+15:0]        prod;
  logic [1:0]            pct_sel;
  logic [63:0]           ovf_wide;

  function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  assign init_busy_o = init_q;
  assign cmd_ready_o = (state_q == B_IDLE) && (cmd_i.op != OP_RPT || !out_valid_q);
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign issue       = (cnt_q != CNT_W'(BucketCount));
  assign walk_done   = !issue && !v1_q && !v2_q && !v3_q;
  assign rd_addr     = (state_q == B_WALK) ? cnt_q[BIDX_W-1:0] : idx_q;
  assign pct_sel     = 2'(step_q - 3'd2);
  assign ovf_wide    = 64'(ovf_q);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = sat_inc(rdata_q);
    if (state_q == B_CLR) begin
      wr_en   = 1'b1;
      wr_addr = cnt_q[BIDX_W-1:0];
      wr_data = '0;
    end else if (state_q == B_ADD_WR) begin
      wr_en = 1'b1;
    end
  end

  always_comb begin
    case (step_q)
      3'd0: mul_m = fmin_q ? MW'(min_idx_q) : MW'(BucketCount);
      3'd1: mul_m = (ovf_q != '0) ? MW'(BucketCount) : MW'(last_idx_q) + MW'(1);
      default: mul_m = pf_q[pct_sel] ? MW'({pidx_q[pct_sel], 1'b1}) : MW'(2 * BucketCount);
    endcase
    prod = (MW+16)'(mul_m) * (MW+16)'(width_i);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLR;
      init_q      <= 1'b1;
      cnt_q       <= '0;
      idx_q       <= '0;
      acc_q       <= '0;
      ovf_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      i1_q        <= '0;
      i2_q        <= '0;
      i3_q        <= '0;
      scaled_q    <= '0;
      cum_q       <= '0;
      kn_q        <= '{default: '0};
      pf_q        <= '0;
      pidx_q      <= '{default: '0};
      fmin_q      <= 1'b0;
      min_idx_q   <= '0;
      last_idx_q  <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      empty_q     <= 1'b0;
      sat_q       <= 1'b0;
      ovf_cnt_q   <= '0;
      min_q       <= '0;
      max_q       <= '0;
      pct_q       <= '{default: '0};
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_CLR: begin
          if (cnt_q == CNT_W'(BucketCount - 1)) begin
            state_q <= B_IDLE;
            init_q  <= 1'b0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        B_IDLE: begin
          if (pop) begin
            case (cmd_i.op)
              OP_ADD: begin
                acc_q <= sat_inc(acc_q);
                if (cmd_i.ovf) begin
                  ovf_q <= sat_inc(ovf_q);
                end else begin
                  idx_q   <= cmd_i.idx[BIDX_W-1:0];
                  state_q <= B_ADD_RD;
                end
              end
              OP_CLR: begin
                acc_q   <= '0;
                ovf_q   <= '0;
                cnt_q   <= '0;
                state_q <= B_CLR;
              end
              OP_RPT: begin
                if (acc_q == '0) begin
                  out_valid_q <= 1'b1;
                  empty_q     <= 1'b1;
                  sat_q       <= 1'b0;
                  ovf_cnt_q   <= '0;
                  min_q       <= '0;
                  max_q       <= '0;
                  pct_q       <= '{default: '0};
                end else begin
                  for (int p = 0; p < 4; p++) begin
                    kn_q[p] <= SCL_W'(acc_q) * SCL_W'(RANK_K[p]);
                  end
                  cum_q   <= '0;
                  pf_q    <= '0;
                  fmin_q  <= 1'b0;
                  cnt_q   <= '0;
                  v1_q    <= 1'b0;
                  v2_q    <= 1'b0;
                  v3_q    <= 1'b0;
                  state_q <= B_WALK;
                end
              end
              default: state_q <= B_IDLE;
            endcase
          end
        end
        B_ADD_RD: state_q <= B_ADD_WR;
        B_ADD_WR: state_q <= B_IDLE;
        B_WALK: begin
          v1_q <= issue;
          i1_q <= cnt_q[BIDX_W-1:0];
          if (issue) begin
            cnt_q <= cnt_q + 1'b1;
          end
          v2_q     <= v1_q;
          i2_q     <= i1_q;
          scaled_q <= SCL_W'(rdata_q) * SCL_W'(RANK_SCALE);
          if (v1_q && rdata_q != '0) begin
            if (!fmin_q) begin
              fmin_q    <= 1'b1;
              min_idx_q <= i1_q;
            end
            last_idx_q <= i1_q;
          end
          v3_q <= v2_q;
          i3_q <= i2_q;
          if (v2_q) begin
            cum_q <= cum_q + SUM_W'(scaled_q);
          end
          for (int p = 0; p < 4; p++) begin
            if (v3_q && !pf_q[p] && cum_q >= SUM_W'(kn_q[p])) begin
              pf_q[p]   <= 1'b1;
              pidx_q[p] <= i3_q;
            end
          end
          if (walk_done) begin
            step_q  <= '0;
            state_q <= B_MUL;
          end
        end
        B_MUL: begin
          case (step_q)
            3'd0:    min_q <= 25'(prod);
            3'd1:    max_q <= 25'(prod);
            default: pct_q[pct_sel] <= 26'(prod);
          endcase
          step_q <= step_q + 3'd1;
          if (step_q == 3'd5) begin
            out_valid_q <= 1'b1;
            empty_q     <= 1'b0;
            sat_q       <= (ovf_q != '0);
            ovf_cnt_q   <= (ovf_wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ovf_wide[31:0];
            state_q     <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.is_empty  = empty_q;
  assign out_o.min_ns    = min_q;
  assign out_o.max_ns    = max_q;
  assign out_o.sat_flag  = sat_q;
  assign out_o.ovf_count = ovf_cnt_q;
  assign out_o.p50_x2    = pct_q[0];
  assign out_o.p99_x2    = pct_q[1];
  assign out_o.p999_x2   = pct_q[2];
  assign out_o.p9999_x2  = pct_q[3];

  a_ovf_le_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q <= acc_q) else $error("overflow count exceeds accepted count");

  a_clr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_CLR) |-> (acc_q == '0 && ovf_q == '0))
    else $error("counters not zero during clear sweep");

  a_init_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_q |-> (state_q == B_CLR)) else $error("init flag outside clear sweep");

  a_mul_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_MUL) |-> !(v1_q || v2_q || v3_q))
    else $error("walk pipeline not drained");

  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && empty_q) |-> (!sat_q && ovf_cnt_q == '0 && max_q == '0))
    else $error("empty report carries data");

endmodule

`default_nettype wire
